FILE: rtl/core/positional_list_insert_delete_macros.svh
// assertion macros for the positional list block
// used by the top level, which supplies clk and rst_n in scope
`ifndef POSITIONAL_LIST_INSERT_DELETE_MACROS_SVH
`define POSITIONAL_LIST_INSERT_DELETE_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked outside reset
`define PLID_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("positional list assertion failed");
// next-cycle implication, checked outside reset
`define PLID_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("positional list assertion failed");
`else
`define PLID_ASSERT_IMP(lbl, ante, cons)
`define PLID_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/core/plid_pkg.sv
// shared types and constants for the positional list block
// no dependencies; imported by the cell, the search tree and the top level
package plid_pkg;

    // count and index width wide enough for the largest supported capacity
    localparam int unsigned CNT_W = 11;

    typedef enum logic [2:0] {
        OP_GET    = 3'd0,
        OP_LOCATE = 3'd1,
        OP_INSERT = 3'd2,
        OP_DELETE = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_LAUNCH = 2'd1,
        S_SEARCH = 2'd2,
        S_COMMIT = 2'd3
    } state_t;

    typedef struct packed {
        op_t                operation;
        logic [6:0]         position;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] read_value;
        logic [6:0]         found_position;
        logic [6:0]         list_length;
        logic               is_empty;
    } rsp_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        cmd_t               cmd;
        logic               locate;
        logic [CNT_W-1:0]   idx;
        logic [CNT_W-1:0]   count;
        logic signed [31:0] key;
    } cell_ctrl_t;

endpackage

FILE: rtl/core/plid_cell.sv
// one list slot: holds an entry, shifts with its neighbors, flags a search hit
// depends on plid_pkg
module plid_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic                  clk,
    input  plid_pkg::cell_ctrl_t  ctrl,
    input  logic signed [31:0]    left_data,
    input  logic signed [31:0]    right_data,
    output logic signed [31:0]    data,
    output logic                  hit
);
    import plid_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic signed [31:0] data_reg;
    logic signed [31:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.cmd)
            CMD_INSERT:
            begin
                if (MY_IDX == ctrl.idx)
                begin
                    data_next = ctrl.key;
                end
                else if (MY_IDX > ctrl.idx)
                begin
                    data_next = left_data;
                end
            end
            CMD_DELETE:
            begin
                if (MY_IDX >= ctrl.idx)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // locate matches live entries by value, get and delete match by slot
    assign hit  = ctrl.locate ? ((data_reg == ctrl.key) && (MY_IDX < ctrl.count))
                              : (MY_IDX == ctrl.idx);
    assign data = data_reg;

endmodule

FILE: rtl/core/plid_tree.sv
// registered priority tree: picks the lowest-index flagged cell and its entry
// depends on plid_pkg for nothing but house style; standalone logic
module plid_tree #(
    parameter int unsigned LEAVES = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [LEAVES-1:0]            hit,
    input  logic signed [31:0]           data [LEAVES],
    output logic                         done,
    output logic                         found,
    output logic [$clog2(LEAVES)-1:0]    index,
    output logic signed [31:0]           value
);
    import plid_pkg::*;

    localparam int unsigned LEVELS = $clog2(LEAVES);
    localparam int unsigned SPAN   = 1 << LEVELS;

    // heap layout: node 1 is the root, leaves sit at SPAN .. 2*SPAN-1
    logic                    node_valid_reg [1:2*SPAN-1];
    logic [LEVELS-1:0]       node_index_reg [1:2*SPAN-1];
    logic signed [31:0]      node_data_reg  [1:2*SPAN-1];
    logic [LEVELS:0]         stage_reg;

    for (genvar j = 0; j < SPAN; j++)
    begin : g_leaf
        if (j < LEAVES)
        begin : g_real
            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    node_valid_reg[SPAN+j] <= hit[j];
                    node_index_reg[SPAN+j] <= LEVELS'(j);
                    node_data_reg[SPAN+j]  <= data[j];
                end
            end
        end
        else
        begin : g_pad
            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    node_valid_reg[SPAN+j] <= 1'b0;
                    node_index_reg[SPAN+j] <= LEVELS'(j);
                    node_data_reg[SPAN+j]  <= '0;
                end
            end
        end
    end

    // left child wins, so the lowest flagged index reaches the root
    for (genvar n = 1; n < SPAN; n++)
    begin : g_node
        always_ff @(posedge clk)
        begin
            if (node_valid_reg[2*n])
            begin
                node_valid_reg[n] <= 1'b1;
                node_index_reg[n] <= node_index_reg[2*n];
                node_data_reg[n]  <= node_data_reg[2*n];
            end
            else
            begin
                node_valid_reg[n] <= node_valid_reg[2*n+1];
                node_index_reg[n] <= node_index_reg[2*n+1];
                node_data_reg[n]  <= node_data_reg[2*n+1];
            end
        end
    end

    // one level per cycle; root is settled when the token falls out the bottom
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= {start, stage_reg[LEVELS:1]};
        end
    end

    assign done  = stage_reg[0];
    assign found = node_valid_reg[1];
    assign index = node_index_reg[1];
    assign value = node_data_reg[1];

endmodule

FILE: rtl/core/positional_list_insert_delete.sv
// Positional list of signed 32-bit entries, up to CAPACITY of them.
// Request channel (req, req_valid, req_stall) carries one operation per
// transaction: get, locate, insert, delete or clear. Response channel (rsp,
// rsp_valid, rsp_stall) returns exactly one result per request, in order.
// Entries live in a chain of cells; insert and delete shift the cells at and
// above the target slot toward or from their neighbors. Get, locate and the read
// half of delete go through a registered priority tree of L = clog2(CAPACITY)
// levels, one level per cycle.
// Each request passes through the launch, search and commit steps, and the
// search step lasts until the tree has settled, which is set by its depth;
// one request is in flight at a time, so the block accepts a new request
// only once the previous one has committed.
// A finished response waits in the output register; while rsp_stall is high
// the block still accepts the next request and holds it at the commit step
// until the output register frees up.
// Reset empties the list at once (the count goes to zero; cell contents are
// left as they are and are never read before being written).
// list_length and found_position are 7 bits and wrap for counts above 127.
`include "positional_list_insert_delete_macros.svh"

module positional_list_insert_delete #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  plid_pkg::req_t  req,
    input  logic            req_valid,
    output logic            req_stall,
    output plid_pkg::rsp_t  rsp,
    output logic            rsp_valid,
    input  logic            rsp_stall
);
    import plid_pkg::*;

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned IW = $clog2(CAPACITY);

    state_t             state_reg, state_next;
    req_t               cur_reg;
    logic [CW-1:0]      count_reg, count_next;
    rsp_t               rsp_reg, rsp_next;
    logic               rsp_valid_reg;
    logic               accept;
    logic               tree_start;
    logic               commit;
    cmd_t               cmd;
    cell_ctrl_t         ctrl;
    logic [CNT_W-1:0]   cnt_w;
    logic [CNT_W-1:0]   pos_w;
    logic               pos_ok_rd;
    logic               pos_ok_ins;
    logic [CNT_W-1:0]   found_w;
    logic [CNT_W-1:0]   len_w;

    logic signed [31:0] cell_data [CAPACITY];
    logic [CAPACITY-1:0] cell_hit;
    logic               tree_done;
    logic               tree_found;
    logic [IW-1:0]      tree_index;
    logic signed [31:0] tree_value;

    assign cnt_w      = CNT_W'(count_reg);
    assign pos_w      = CNT_W'(cur_reg.position);
    assign pos_ok_rd  = (cur_reg.position != 7'd0) && (pos_w <= cnt_w);
    assign pos_ok_ins = (cur_reg.position != 7'd0) && (pos_w <= cnt_w + CNT_W'(1));
    assign found_w    = CNT_W'(tree_index) + CNT_W'(1);
    assign accept     = req_valid && !req_stall;

    always_comb
    begin
        state_next = state_reg;
        req_stall  = 1'b1;
        tree_start = 1'b0;
        commit     = 1'b0;
        cmd        = CMD_HOLD;
        count_next = count_reg;
        rsp_next   = rsp_reg;
        len_w      = '0;
        case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    state_next = S_LAUNCH;
                end
            end
            S_LAUNCH:
            begin
                tree_start = 1'b1;
                state_next = S_SEARCH;
            end
            S_SEARCH:
            begin
                if (tree_done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    commit     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (commit)
        begin
            rsp_next.status         = STATUS_OK;
            rsp_next.read_value     = '0;
            rsp_next.found_position = '0;
            case (cur_reg.operation)
                OP_GET:
                begin
                    if (pos_ok_rd)
                    begin
                        rsp_next.read_value = tree_value;
                    end
                    else
                    begin
                        rsp_next.status = STATUS_RANGE;
                    end
                end
                OP_LOCATE:
                begin
                    if (tree_found)
                    begin
                        rsp_next.found_position = found_w[6:0];
                    end
                end
                OP_INSERT:
                begin
                    if (!pos_ok_ins)
                    begin
                        rsp_next.status = STATUS_RANGE;
                    end
                    else if (count_reg == CW'(CAPACITY))
                    begin
                        rsp_next.status = STATUS_FULL;
                    end
                    else
                    begin
                        cmd        = CMD_INSERT;
                        count_next = count_reg + CW'(1);
                    end
                end
                OP_DELETE:
                begin
                    if (pos_ok_rd)
                    begin
                        rsp_next.read_value = tree_value;
                        cmd        = CMD_DELETE;
                        count_next = count_reg - CW'(1);
                    end
                    else
                    begin
                        rsp_next.status = STATUS_RANGE;
                    end
                end
                OP_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    cmd = CMD_HOLD;
                end
            endcase
            len_w                = CNT_W'(count_next);
            rsp_next.list_length = len_w[6:0];
            rsp_next.is_empty    = (count_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

    // broadcast to the chain; the slot index is the 1-based position minus one
    assign ctrl.cmd    = cmd;
    assign ctrl.locate = (cur_reg.operation == OP_LOCATE);
    assign ctrl.idx    = pos_w - CNT_W'(1);
    assign ctrl.count  = cnt_w;
    assign ctrl.key    = cur_reg.value;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [31:0] left_src;
        logic signed [31:0] right_src;
        if (i == 0)
        begin : g_first
            assign left_src = cell_data[i];
        end
        else
        begin : g_mid_l
            assign left_src = cell_data[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_last
            assign right_src = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_src = cell_data[i+1];
        end

        plid_cell #(
            .IDX (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .left_data  (left_src),
            .right_data (right_src),
            .data       (cell_data[i]),
            .hit        (cell_hit[i])
        );
    end

    plid_tree #(
        .LEAVES (CAPACITY)
    ) u_tree (
        .clk   (clk),
        .rst_n (rst_n),
        .start (tree_start),
        .hit   (cell_hit),
        .data  (cell_data),
        .done  (tree_done),
        .found (tree_found),
        .index (tree_index),
        .value (tree_value)
    );

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    `PLID_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(CAPACITY))
    `PLID_ASSERT_IMP(a_done_in_search, tree_done, state_reg == S_SEARCH)
    `PLID_ASSERT_NXT(a_commit_shows, commit, rsp_valid && (rsp.list_length == $past(len_w[6:0])))
    `PLID_ASSERT_IMP(a_found_ok, rsp_valid && (rsp.found_position != 7'd0), rsp.status == STATUS_OK)

endmodule

FILE: test/testbench.sv
// testbench for positional_list_insert_delete: directed, full-list and random tests
// checks every response against an in-bench list predictor; needs plid_pkg and the rtl
`timescale 1ns / 1ps

module testbench;
    import plid_pkg::*;

    localparam int LIST_CAP = 64;
    localparam int DRAIN_CYCLES = 40;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

    logic clk = 1'b0;
    logic rst_n;
    req_t req;
    logic req_valid;
    logic req_stall;
    rsp_t rsp;
    logic rsp_valid;
    logic rsp_stall;

    // predictor state
    logic signed [31:0] list_model [0:LIST_CAP-1];
    int list_len = 0;
    rsp_t pending_results [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_count = 0;

    positional_list_insert_delete #(
        .CAPACITY (LIST_CAP)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // applies one operation to the predicted list and returns the expected response
    function automatic rsp_t apply_list_op(input req_t r);
        rsp_t res;
        int p;
        int k;
        res = '0;
        res.status = STATUS_OK;
        p = r.position;
        case (r.operation)
            OP_GET:
            begin
                if (p < 1 || p > list_len)
                    res.status = STATUS_RANGE;
                else
                    res.read_value = list_model[p-1];
            end
            OP_LOCATE:
            begin
                for (k = 0; k < list_len && res.found_position == 0; k++)
                    if (list_model[k] == r.value)
                        res.found_position = 7'(k + 1);
            end
            OP_INSERT:
            begin
                // range check wins over the full check
                if (p < 1 || p > list_len + 1)
                    res.status = STATUS_RANGE;
                else if (list_len >= LIST_CAP)
                    res.status = STATUS_FULL;
                else
                begin
                    for (k = list_len; k > p - 1; k--)
                        list_model[k] = list_model[k-1];
                    list_model[p-1] = r.value;
                    list_len++;
                end
            end
            OP_DELETE:
            begin
                if (p < 1 || p > list_len)
                    res.status = STATUS_RANGE;
                else
                begin
                    res.read_value = list_model[p-1];
                    for (k = p - 1; k + 1 < list_len; k++)
                        list_model[k] = list_model[k+1];
                    list_len--;
                end
            end
            OP_CLEAR:
                list_len = 0;
            default:
                ;
        endcase
        res.list_length = 7'(list_len);
        res.is_empty = (list_len == 0);
        return res;
    endfunction

    function automatic req_t make_req(input op_t op, input int pos, input logic signed [31:0] v);
        req_t r;
        r.operation = op;
        r.position = 7'(pos);
        r.value = v;
        return r;
    endfunction

    function automatic logic signed [31:0] pick_value();
        int sel;
        sel = $urandom_range(9);
        if (sel < 3)
            return $signed(32'($urandom_range(8))) - 32'sd4;
        if (sel == 3)
        begin
            case ($urandom_range(3))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    function automatic int pick_position(input bit for_insert);
        if ($urandom_range(99) < 15)
            return $urandom_range(127);
        if (for_insert)
            return $urandom_range(list_len + 1, 1);
        return $urandom_range(list_len < 1 ? 1 : list_len, 1);
    endfunction

    // called at a rising edge; returns at the edge where the transaction is accepted
    task automatic send_request(input req_t r);
        bit stalled;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req <= r;
        req_valid <= 1'b1;
        do
        begin
            @(negedge clk);
            stalled = req_stall;
            @(posedge clk);
        end while (stalled);
        pending_results.push_back(apply_list_op(r));
    endtask

    task automatic check_field(input string field, input logic signed [32:0] want,
                               input logic signed [32:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    // receiver stall, redrawn every cycle
    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < recv_idle_pct);

    // a response transaction completes at the next rising edge
    always @(negedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("response with no request outstanding");
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", want.status, rsp.status);
                check_field("read_value", want.read_value, rsp.read_value);
                check_field("found_position", want.found_position, rsp.found_position);
                check_field("list_length", want.list_length, rsp.list_length);
                check_field("is_empty", want.is_empty, rsp.is_empty);
            end
        end
    end

    task automatic test_directed();
        int k;
        send_request(make_req(OP_GET, 1, 0));
        send_request(make_req(OP_DELETE, 1, 0));
        send_request(make_req(OP_LOCATE, 0, 0));
        send_request(make_req(OP_INSERT, 0, 5));
        send_request(make_req(OP_INSERT, 2, 5));
        send_request(make_req(OP_INSERT, 1, VAL_MAX));
        send_request(make_req(OP_INSERT, 1, VAL_MIN));
        send_request(make_req(OP_INSERT, 3, -1));
        send_request(make_req(OP_INSERT, 2, 0));
        send_request(make_req(OP_GET, 0, 0));
        send_request(make_req(OP_GET, 4, 0));
        send_request(make_req(OP_GET, 5, 0));
        send_request(make_req(OP_GET, 127, -1));
        send_request(make_req(OP_LOCATE, 0, VAL_MAX));
        send_request(make_req(OP_LOCATE, 127, 12345));
        // duplicate value: locate must still report the first match
        send_request(make_req(OP_INSERT, 5, VAL_MAX));
        send_request(make_req(OP_LOCATE, 0, VAL_MAX));
        send_request(make_req(OP_DELETE, 0, 0));
        send_request(make_req(OP_DELETE, 6, 0));
        send_request(make_req(OP_DELETE, 2, 0));
        send_request(make_req(OP_DELETE, 4, 0));
        for (k = 1; k <= 3; k++)
            send_request(make_req(op_t'(3'(int'(OP_CLEAR) + k)), 127, -1));
        send_request(make_req(OP_CLEAR, 127, -1));
        send_request(make_req(OP_LOCATE, 0, -1));
    endtask

    task automatic test_full_list();
        int k;
        send_request(make_req(OP_CLEAR, 0, 0));
        for (k = 0; k < LIST_CAP; k++)
            send_request(make_req(OP_INSERT, $urandom_range(list_len + 1, 1), pick_value()));
        send_request(make_req(OP_INSERT, $urandom_range(LIST_CAP, 1), VAL_MAX));
        send_request(make_req(OP_INSERT, LIST_CAP + 1, 1));
        send_request(make_req(OP_INSERT, LIST_CAP + 2, 1));
        send_request(make_req(OP_INSERT, 0, 1));
        send_request(make_req(OP_LOCATE, 0, list_model[LIST_CAP-1]));
        send_request(make_req(OP_GET, LIST_CAP, 0));
        send_request(make_req(OP_GET, LIST_CAP + 1, 0));
        send_request(make_req(OP_DELETE, LIST_CAP, 0));
        send_request(make_req(OP_INSERT, LIST_CAP, VAL_MIN));
        send_request(make_req(OP_DELETE, 1, 0));
    endtask

    // alternates insert-heavy and delete-heavy stretches so the list fills and drains
    task automatic test_random(input int n_items);
        req_t r;
        int k;
        int pick;
        bit growing;
        growing = 1'b1;
        for (k = 0; k < n_items; k++)
        begin
            if (k % 200 == 199)
                growing = !growing;
            pick = $urandom_range(99);
            r.value = pick_value();
            r.position = 7'(pick_position(1'b0));
            if (pick < 6)
            begin
                r.operation = op_t'(3'($urandom_range(7)));
                r.position = 7'($urandom_range(127));
                r.value = $urandom;
                if (growing && r.operation == OP_CLEAR)
                    r.operation = OP_GET;
            end
            else if (pick < (growing ? 56 : 26))
            begin
                r.operation = OP_INSERT;
                r.position = 7'(pick_position(1'b1));
            end
            else if (pick < (growing ? 68 : 60))
                r.operation = OP_DELETE;
            else if (pick < 80)
                r.operation = OP_GET;
            else if (pick < 99 || growing)
            begin
                r.operation = OP_LOCATE;
                if (list_len > 0 && $urandom_range(99) < 60)
                    r.value = list_model[$urandom_range(list_len - 1)];
            end
            else
                r.operation = OP_CLEAR;
            send_request(r);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        req = '0;
        req_valid = 1'b0;
        rsp_stall = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 9;
        recv_idle_pct = 61;
        test_directed();
        test_full_list();
        test_random(350);

        send_idle_pct = 61;
        recv_idle_pct = 9;
        test_random(350);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(350);

        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("** positional_list_insert_delete: PASSED **");
        else
            $display("** positional_list_insert_delete: FAILED **");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("** positional_list_insert_delete: FAILED **");
        $finish;
    end

endmodule
